### src/c2d_pkg.sv
// Package: constants and types for the conv2d line buffer ReLU core.
package c2d_pkg;

  localparam int MaxInCh    = 8;
  localparam int MaxFilt    = 16;
  localparam int MaxWidth   = 32;
  localparam int KSize      = 5;
  localparam int DataBits   = 16;
  localparam int FracBits   = 8;
  localparam int KK         = KSize * KSize;
  localparam int RowWords   = MaxInCh * MaxWidth;
  localparam int RowDepth   = KSize * RowWords;
  localparam int WgtDepth   = MaxFilt * MaxInCh * KK;
  localparam int RowAw      = $clog2(RowDepth);
  localparam int WgtAw      = $clog2(WgtDepth);
  localparam int AccBits    = 48;
  localparam int ResultMax  = 32767;

  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_PIXEL  = 2'd2,
    ACT_PULL   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_VALUE   = 2'd1,
    ST_NONE    = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN1,
    S_DRAIN2,
    S_BIAS,
    S_DONE
  } state_t;

  localparam logic [1:0] CFG_IN_CH  = 2'd0;
  localparam logic [1:0] CFG_OUT_CH = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

endpackage

### src/c2d_ram.sv
// Generic single-port-write, registered-read RAM.
module c2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/conv2d_line_buffer_relu_core.sv
// Top level: 5x5 convolution with bias and ReLU over a streamed row buffer.
//
// Usage: one input transaction carries action on in_tuser and index and value
// on in_tdata. Each transaction yields exactly one result transaction on out_*.
//   Weight load, bias load, pixel, and a pull with nothing pending show
//   their result the cycle after acceptance; the next transaction can be
//   taken once that result has left the output register. A pull with an
//   output pending runs a multiply-accumulate sequence over
//   in_channels x 25 taps through one shared 16x16 multiplier, one tap per
//   cycle; the drain states S_DRAIN1 and S_DRAIN2, a bias/saturation state
//   and the output register follow before the result is valid.
// The core takes one transaction at a time: in_tready is high only while
// the sequencer is idle and the output register is empty.
// Configuration: cfg_we writes register cfg_addr (0 in_channels, 1
// out_channels, 2 image_width, 3 image_height) from cfg_wdata.
// Reset (rst_n low, synchronous) clears counters and configuration to
// 3, 6, 32, 32; the weight, bias and row memories are not cleared.
// When out_tready is low the result stays in the output register and no
// new transaction is taken until it leaves.
module conv2d_line_buffer_relu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] index, [27:12] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] result
  output logic [2:0]  out_tuser,  // [1:0] status, [2] frame_last
  output logic        out_tlast   // row_last
);
  import c2d_pkg::*;

  // configuration
  logic [3:0] cfg_ich_r;
  logic [4:0] cfg_och_r;
  logic [5:0] cfg_w_r, cfg_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ich_r <= 4'd3;
      cfg_och_r <= 5'd6;
      cfg_w_r   <= 6'd32;
      cfg_h_r   <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IN_CH:  cfg_ich_r <= cfg_wdata[3:0];
        CFG_OUT_CH: cfg_och_r <= cfg_wdata[4:0];
        CFG_WIDTH:  cfg_w_r   <= cfg_wdata;
        CFG_HEIGHT: cfg_h_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective (clamped) configuration
  logic [3:0] eff_ch;
  logic [4:0] eff_f;
  logic [5:0] eff_w, eff_h, out_cols;
  always_comb begin
    eff_ch = (cfg_ich_r == 4'd0) ? 4'd1 : (cfg_ich_r > 4'd8 ? 4'd8 : cfg_ich_r);
    eff_f  = (cfg_och_r == 5'd0) ? 5'd1 : (cfg_och_r > 5'd16 ? 5'd16 : cfg_och_r);
    eff_w  = (cfg_w_r < 6'd5) ? 6'd5 : (cfg_w_r > 6'd32 ? 6'd32 : cfg_w_r);
    eff_h  = (cfg_h_r < 6'd5) ? 6'd5 : cfg_h_r;
    out_cols = eff_w - 6'd4;
  end

  // input fields
  action_t      act;
  logic [11:0]  idx;
  logic [15:0]  val;
  assign act = action_t'(in_tuser);
  assign idx = in_tdata[11:0];
  assign val = in_tdata[27:12];

  // state
  state_t      state_r, state_nxt;
  logic [2:0]  oldest_r;
  logic [5:0]  rows_r;
  logic [2:0]  pch_r;
  logic [4:0]  pcol_r;
  logic [3:0]  ofilt_r;
  logic [4:0]  ocol_r;
  logic        pend_r;
  logic        ovalid_r;
  logic [1:0]  ostat_r;
  logic [14:0] ores_r;
  logic        orow_r, oframe_r;

  // mac sequencer counters: channel, kernel row, kernel column
  logic [2:0]  md_r;
  logic [2:0]  mr_r, mc_r;
  logic [2:0]  mslot_r;
  logic [WgtAw-1:0] mwa_r;
  logic        v1_r, v2_r;    // read and product stage valid
  logic        pxz1_r;        // column beyond store reads zero
  logic signed [31:0] prod_r;
  logic signed [AccBits-1:0] acc_r;

  logic fire_in;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign fire_in = in_tvalid && in_tready;

  // memories
  logic             row_we, wgt_we, bias_we;
  logic [RowAw-1:0] row_waddr, row_raddr;
  logic [WgtAw-1:0] wgt_raddr;
  logic [15:0]      row_rdata, wgt_rdata, bias_rdata;

  logic [2:0] fill, wslot;
  logic [3:0] wsum;
  always_comb begin
    fill  = (rows_r < 6'd4) ? rows_r[2:0] : 3'd4;
    wsum  = {1'b0, oldest_r} + {1'b0, fill};
    wslot = (wsum >= 4'd5) ? 3'(wsum - 4'd5) : wsum[2:0];
  end

  // row address: slot, channel, column (256 words per slot)
  assign row_we    = fire_in && act == ACT_PIXEL && !pend_r;
  assign row_waddr = {wslot, pch_r, pcol_r};
  assign wgt_we    = fire_in && act == ACT_WEIGHT && idx < 12'(WgtDepth);
  assign bias_we   = fire_in && act == ACT_BIAS && idx < 12'(MaxFilt);

  logic [5:0] mcol;
  assign mcol = {1'b0, ocol_r} + {3'd0, mc_r};
  assign row_raddr = {mslot_r, md_r, mcol[4:0]};
  assign wgt_raddr = mwa_r;

  c2d_ram #(.Width(16), .Depth(RowDepth)) u_row (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(val),
    .raddr(row_raddr), .rdata(row_rdata));
  c2d_ram #(.Width(16), .Depth(WgtDepth)) u_wgt (
    .clk, .we(wgt_we), .waddr(idx[WgtAw-1:0]), .wdata(val),
    .raddr(wgt_raddr), .rdata(wgt_rdata));
  c2d_ram #(.Width(16), .Depth(MaxFilt)) u_bias (
    .clk, .we(bias_we), .waddr(idx[3:0]), .wdata(val),
    .raddr(ofilt_r), .rdata(bias_rdata));

  // last tap of the sequence
  logic mac_last;
  assign mac_last = (mc_r == 3'd4) && (mr_r == 3'd4) && (md_r == 3'(eff_ch - 4'd1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (fire_in && act == ACT_PULL && pend_r) state_nxt = S_MAC;
      S_MAC:    if (mac_last) state_nxt = S_DRAIN1;
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_BIAS;
      S_BIAS:   state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // mac datapath
  logic signed [AccBits-1:0] acc_b, shifted;
  always_comb begin
    acc_b   = acc_r + (AccBits'($signed(bias_rdata)) <<< FracBits);
    shifted = acc_b >>> FracBits;
  end

  always_ff @(posedge clk) begin
    v1_r   <= (state_r == S_MAC);
    pxz1_r <= mcol[5];
    v2_r   <= v1_r;
    prod_r <= pxz1_r ? 32'sd0 : $signed(row_rdata) * $signed(wgt_rdata);
    if (state_r == S_IDLE) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + AccBits'(prod_r);
    end
    if (state_r == S_IDLE) begin
      md_r    <= '0;
      mr_r    <= '0;
      mc_r    <= '0;
      mslot_r <= oldest_r;
      mwa_r   <= WgtAw'(ofilt_r) * WgtAw'(eff_ch) * WgtAw'(KK);
    end else if (state_r == S_MAC) begin
      mwa_r <= mwa_r + WgtAw'(1);
      if (mc_r == 3'd4) begin
        mc_r <= '0;
        if (mr_r == 3'd4) begin
          mr_r    <= '0;
          md_r    <= md_r + 3'd1;
          mslot_r <= oldest_r;
        end else begin
          mr_r    <= mr_r + 3'd1;
          mslot_r <= (mslot_r == 3'd4) ? 3'd0 : mslot_r + 3'd1;
        end
      end else begin
        mc_r <= mc_r + 3'd1;
      end
    end
  end

  // item bookkeeping and output register
  logic [4:0] ocol_inc;
  logic [4:0] ofilt_inc;
  assign ocol_inc  = ocol_r + 5'd1;
  assign ofilt_inc = {1'b0, ofilt_r} + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0; rows_r <= '0; pch_r <= '0; pcol_r <= '0;
      ofilt_r  <= '0; ocol_r <= '0; pend_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (fire_in) begin
        ostat_r  <= ST_OK;
        ores_r   <= '0;
        orow_r   <= 1'b0;
        oframe_r <= 1'b0;
        case (act)
          ACT_WEIGHT, ACT_BIAS: ovalid_r <= 1'b1;
          ACT_PIXEL: begin
            ovalid_r <= 1'b1;
            if (pend_r) begin
              ostat_r <= ST_BUSY;
            end else if ({1'b0, pcol_r} + 6'd1 >= eff_w) begin
              pcol_r <= '0;
              if ({1'b0, pch_r} + 4'd1 >= eff_ch) begin
                pch_r  <= '0;
                rows_r <= rows_r + 6'd1;
                if (rows_r + 6'd1 >= 6'd5) begin
                  pend_r <= 1'b1; ofilt_r <= '0; ocol_r <= '0;
                end
              end else begin
                pch_r <= pch_r + 3'd1;
              end
            end else begin
              pcol_r <= pcol_r + 5'd1;
            end
          end
          default: begin
            if (!pend_r) begin
              ovalid_r <= 1'b1;
              ostat_r  <= ST_NONE;
            end
          end
        endcase
      end else if (state_r == S_BIAS) begin
        ostat_r  <= ST_VALUE;
        ores_r   <= acc_b[AccBits-1] ? 15'd0 :
                    (shifted > AccBits'(ResultMax) ? 15'(ResultMax) : shifted[14:0]);
        orow_r   <= 1'b0;
        oframe_r <= 1'b0;
      end else if (state_r == S_DONE) begin
        ovalid_r <= 1'b1;
        if ({1'b0, ocol_inc} >= out_cols) begin
          ocol_r <= '0;
          if (ofilt_inc >= eff_f) begin
            ofilt_r <= '0;
            pend_r  <= 1'b0;
            orow_r  <= 1'b1;
            if (rows_r >= eff_h) begin
              oframe_r <= 1'b1;
              rows_r   <= '0;
              oldest_r <= '0;
              pch_r    <= '0;
              pcol_r   <= '0;
            end else begin
              oldest_r <= (oldest_r == 3'd4) ? 3'd0 : oldest_r + 3'd1;
            end
          end else begin
            ofilt_r <= ofilt_inc[3:0];
          end
        end else begin
          ocol_r <= ocol_inc;
        end
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, ores_r};
  assign out_tuser  = {oframe_r, ostat_r};
  assign out_tlast  = orow_r;

endmodule

### tb/tb.sv
// Testbench for conv2d_line_buffer_relu_core: stores, line buffer, convolution, flow control.
`timescale 1ns / 1ps

module tb;
  import c2d_pkg::*;

  localparam int HoldCycles = 400;
  localparam int IdleLimit  = 4000;
  localparam int WgtFill    = 50;

  typedef struct packed {
    status_t     status;
    logic [14:0] result;
    logic        row_last;
    logic        frame_last;
  } conv_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [5:0]  cfg_wdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  conv2d_line_buffer_relu_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow of the block: stores, counters and registers
  logic signed [15:0] wgt_mem [WgtDepth];
  logic signed [15:0] bias_mem [MaxFilt];
  logic signed [15:0] row_mem [RowDepth];
  int unsigned oldest_slot, rows_in, px_ch, px_col, o_filt, o_col;
  bit          pending;
  int unsigned reg_in_ch, reg_out_ch, reg_width, reg_height;

  conv_out_t expected_q[$];
  int        errors;
  int        items_sent;
  int        results_seen;
  int        images_done;
  int        burst_left;
  bit        hold_go;
  bit        hold_taken;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned eff_ch();
    return clamp_u(reg_in_ch, 1, MaxInCh);
  endfunction

  function automatic int unsigned eff_filt();
    return clamp_u(reg_out_ch, 1, MaxFilt);
  endfunction

  function automatic int unsigned eff_width();
    return clamp_u(reg_width, KSize, MaxWidth);
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height < KSize) ? KSize : reg_height;
  endfunction

  // One window sum: bias, ReLU, shift back, saturate
  function automatic logic [14:0] window_sum();
    longint acc;
    longint px;
    longint wt;
    int unsigned ch;
    int unsigned slot;
    int unsigned col;
    int unsigned wa;
    acc = 0;
    ch  = eff_ch();
    for (int unsigned d = 0; d < ch; d++) begin
      for (int unsigned r = 0; r < KSize; r++) begin
        slot = (oldest_slot + r) % KSize;
        for (int unsigned c = 0; c < KSize; c++) begin
          col = o_col + c;
          wa  = o_filt * ch * KK + d * KK + r * KSize + c;
          px  = (col < MaxWidth) ? longint'(row_mem[slot * RowWords + d * MaxWidth + col]) : 0;
          wt  = (wa < WgtDepth) ? longint'(wgt_mem[wa]) : 0;
          acc += px * wt;
        end
      end
    end
    if (o_filt < MaxFilt) acc += longint'(bias_mem[o_filt]) * (longint'(1) << FracBits);
    if (acc < 0) return 15'd0;
    acc = acc >>> FracBits;
    return (acc > ResultMax) ? 15'(ResultMax) : 15'(acc);
  endfunction

  // Advance the shadow by one input transaction and return its result
  function automatic conv_out_t conv_step(action_t act, logic [11:0] idx, logic signed [15:0] val);
    conv_out_t   res;
    int unsigned fill;
    int unsigned slot;
    res = '{status: ST_OK, result: 15'd0, row_last: 1'b0, frame_last: 1'b0};
    case (act)
      ACT_WEIGHT: begin
        if (idx < WgtDepth) wgt_mem[idx] = val;
      end
      ACT_BIAS: begin
        if (idx < MaxFilt) bias_mem[idx] = val;
      end
      ACT_PIXEL: begin
        if (pending) begin
          res.status = ST_BUSY;
        end else begin
          fill = (rows_in < KSize - 1) ? rows_in : KSize - 1;
          slot = (oldest_slot + fill) % KSize;
          if (px_ch < MaxInCh && px_col < MaxWidth)
            row_mem[slot * RowWords + px_ch * MaxWidth + px_col] = val;
          px_col++;
          if (px_col >= eff_width()) begin
            px_col = 0;
            px_ch++;
            if (px_ch >= eff_ch()) begin
              px_ch   = 0;
              rows_in = (rows_in + 1) & 6'h3f;
              if (rows_in >= KSize) begin
                pending = 1'b1;
                o_filt  = 0;
                o_col   = 0;
              end
            end
          end
        end
      end
      default: begin
        if (!pending) begin
          res.status = ST_NONE;
        end else begin
          res.status = ST_VALUE;
          res.result = window_sum();
          o_col++;
          if (o_col >= eff_width() - KSize + 1) begin
            o_col = 0;
            o_filt++;
            if (o_filt >= eff_filt()) begin
              o_filt       = 0;
              pending      = 1'b0;
              res.row_last = 1'b1;
              if (rows_in >= eff_height()) begin
                res.frame_last = 1'b1;
                rows_in     = 0;
                oldest_slot = 0;
                px_ch       = 0;
                px_col      = 0;
              end else begin
                oldest_slot = (oldest_slot + 1) % KSize;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Mostly small Q8.8 values so sums stay in range; now and then full range
  function automatic logic signed [15:0] rand_q88(int unsigned mag);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 2 * mag)) - $signed(mag));
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Send one transaction; the sender runs in bursts with random gaps
  task automatic send_txn(action_t act, logic [11:0] idx, logic signed [15:0] val,
                          output conv_out_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    res = conv_step(act, idx, val);
    expected_q.push_back(res);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, val, idx};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // Drain all expected results; the block is idle afterwards
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [5:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_IN_CH:  reg_in_ch  = data & 6'h0f;
      CFG_OUT_CH: reg_out_ch = data & 6'h1f;
      CFG_WIDTH:  reg_width  = data;
      default:    reg_height = data;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(int ch, int filt, int w, int h);
    wait_drained();
    write_reg(CFG_IN_CH, 6'(ch));
    write_reg(CFG_OUT_CH, 6'(filt));
    write_reg(CFG_WIDTH, 6'(w));
    write_reg(CFG_HEIGHT, 6'(h));
  endtask

  // Stream one whole image; noise_pct adds stray pulls, busy pixels and reloads
  task automatic stream_image(int noise_pct);
    conv_out_t res;
    int        pick;
    res = '0;
    while (!res.frame_last) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: send_txn(ACT_WEIGHT, 12'($urandom_range(0, WgtDepth - 1)), rand_q88(64), res);
          1: send_txn(ACT_BIAS, 12'($urandom_range(0, MaxFilt - 1)), rand_q88(256), res);
          2: send_txn(ACT_WEIGHT, 12'($urandom_range(WgtDepth, 4095)), 16'($urandom), res);
          default: send_txn(pending ? ACT_PIXEL : ACT_PULL, 12'($urandom), 16'($urandom), res);
        endcase
        res.frame_last = 1'b0;
      end else if (pending) begin
        send_txn(ACT_PULL, 12'($urandom), 16'($urandom), res);
      end else begin
        send_txn(ACT_PIXEL, 12'($urandom), rand_q88(512), res);
      end
    end
    images_done++;
  endtask

  // Fill the weights and biases that the shapes below read (filters x channels <= 2)
  task automatic test_store_load();
    conv_out_t res;
    for (int i = 0; i < WgtFill; i++)
      send_txn(ACT_WEIGHT, 12'(i), (i < 2) ? ((i == 0) ? 16'sh8000 : 16'sh7fff) : rand_q88(64), res);
    for (int i = 0; i < MaxFilt; i++) send_txn(ACT_BIAS, 12'(i), rand_q88(256), res);
    // highest in-range address; out-of-range addresses are dropped
    send_txn(ACT_WEIGHT, 12'(WgtDepth - 1), 16'sh1357, res);
    send_txn(ACT_WEIGHT, 12'hfff, 16'sh7fff, res);
    send_txn(ACT_BIAS, 12'd16, 16'sh8000, res);
    send_txn(ACT_BIAS, 12'hfff, 16'sh1234, res);
  endtask

  // Smallest image, empty pull, busy pixel and ReLU floor via the bias
  task automatic test_directed();
    conv_out_t res;
    set_shape(1, 1, 5, 5);
    send_txn(ACT_PULL, 12'hfff, 16'shffff, res);
    send_txn(ACT_BIAS, 12'd0, 16'sh8000, res);
    for (int i = 0; i < 24; i++)
      send_txn(ACT_PIXEL, 12'd0, (i % 2) ? 16'sh7fff : 16'sh8000, res);
    send_txn(ACT_PIXEL, 12'd0, 16'sh0000, res);
    send_txn(ACT_PIXEL, 12'd0, 16'sh0100, res);
    send_txn(ACT_PULL, 12'd0, 16'sh0000, res);
    send_txn(ACT_PULL, 12'd0, 16'sh0000, res);
    send_txn(ACT_BIAS, 12'd0, 16'sh7fff, res);
  endtask

  // Register extremes that the block clamps; bias 0 is reloaded between the two images
  task automatic test_shape_extremes();
    conv_out_t res;
    set_shape(0, 0, 0, 0);
    stream_image(5);
    send_txn(ACT_BIAS, 12'd0, 16'sh0040, res);
    set_shape(1, 1, 63, 5);
    stream_image(5);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    set_shape(1, 2, 6, 6);
    hold_go = 1'b1;
    stream_image(10);
  endtask

  task automatic test_random(int target);
    int ch;
    while (items_sent < target) begin
      ch = $urandom_range(1, 2);
      set_shape(ch, (ch == 2) ? 1 : $urandom_range(1, 2), $urandom_range(5, 8),
                $urandom_range(5, 7));
      stream_image(15);
    end
  endtask

  // Result checker with its own stall pattern
  int stall_pct;
  int stall_phase;
  int hold_cnt;
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        if (out_tuser[1:0] != expected_q[0].status)
          report_mismatch("status", out_tuser[1:0], expected_q[0].status);
        if (out_tdata[14:0] != expected_q[0].result)
          report_mismatch("result", out_tdata[14:0], expected_q[0].result);
        if (out_tlast != expected_q[0].row_last)
          report_mismatch("row_last", out_tlast, expected_q[0].row_last);
        if (out_tuser[2] != expected_q[0].frame_last)
          report_mismatch("frame_last", out_tuser[2], expected_q[0].frame_last);
        void'(expected_q.pop_front());
      end
    end
    stall_phase = stall_phase + 1;
    if (stall_phase % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
    end
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cnt   = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: cycles without any accepted transaction
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no transaction for %0d cycles", IdleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WgtDepth; i++) wgt_mem[i] = '0;
    for (int i = 0; i < MaxFilt; i++) bias_mem[i] = '0;
    for (int i = 0; i < RowDepth; i++) row_mem[i] = '0;
    oldest_slot = 0; rows_in = 0; px_ch = 0; px_col = 0; o_filt = 0; o_col = 0;
    pending    = 1'b0;
    reg_in_ch  = 3; reg_out_ch = 6; reg_width = 32; reg_height = 32;
    errors = 0; items_sent = 0; results_seen = 0; images_done = 0; burst_left = 0;
    hold_go = 1'b0; hold_taken = 1'b0;
    stall_pct = 0; stall_phase = 0; hold_cnt = 0; idle_cycles = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    out_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_store_load();
    test_directed();
    test_shape_extremes();
    test_backpressure();
    test_random(400);
    wait_drained();
    repeat (250) @(posedge clk);

    $display("Covered %0d input transactions, %0d results, %0d complete images",
             items_sent, results_seen, images_done);
    $display("Shapes: 1 to 2 channels, 1 to 2 filters, widths 5 to 32 with clamping, heights 5 to 7");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
